### rtl/rgb555_hue_rotate_defines.svh
// Assertion macros for the RGB555 hue rotator.
// Used by the top level; the checks drop out when ASSERT_OFF is defined.
`ifndef RGB555_HUE_ROTATE_DEFINES_SVH
`define RGB555_HUE_ROTATE_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked only while out of reset.
`define RHR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rhr assertion failed");
// Checked at every edge, reset included.
`define RHR_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("rhr reset assertion failed");
`else
`define RHR_ASSERT(lbl, prop)
`define RHR_ASSERT_RST(lbl, prop)
`endif
`endif

### rtl/rhr_pkg.sv
// Shared types and constants for the RGB555 hue rotator.
// No dependencies.
`timescale 1ns / 1ps
package rhr_pkg;
    localparam int COLOR_W   = 15;
    localparam int CH_W      = 5;
    localparam int COS_W     = 11;
    localparam int SIN_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DW    = 12;
    localparam int COEF_W    = 13;
    localparam int PROD_W    = 19;
    localparam int SUM_W     = 20;
    localparam int FRAC      = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_COSINE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINE   = 1'd1;

    localparam logic [COS_W-1:0]   COS_RESET  = 11'd1024;
    localparam logic signed [SIN_W-1:0] SIN_RESET = 12'sd0;

    localparam logic signed [COEF_W-1:0] K_ONE        = 13'sd1024;
    localparam logic signed [COEF_W-1:0] K_THIRD      = 13'sd341;   // 0x155
    localparam logic [9:0]               K_TWO_THIRDS = 10'd682;    // 0x2AA
    localparam logic signed [10:0]       K_THIRD_S    = 11'sd341;
    localparam logic signed [10:0]       K_ROOT_THIRD = 11'sd591;   // 0x24F
    localparam logic signed [SUM_W-1:0]  K_HALF       = 20'sd512;
    localparam logic signed [SUM_W-1:0]  K_TOP        = 20'sd32768;
    localparam logic [CH_W-1:0]          CH_MAX       = 5'h1F;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;

    // One color on its way from front to back, with its coefficients.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               transp;
        t_coef              c1;
        t_coef              c2;
        t_coef              c3;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;
endpackage

### rtl/rhr_in_if.sv
// Input channel: one packed color and its transparent flag.
// Depends on rhr_pkg.
`timescale 1ns / 1ps
interface rhr_in_if import rhr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color_in;
    logic               transparent_slot;

    modport source(output valid, color_in, transparent_slot, input ready);
    modport sink(input valid, color_in, transparent_slot, output ready);
endinterface

### rtl/rhr_out_if.sv
// Output channel: one hue-rotated packed color.
// Depends on rhr_pkg.
`timescale 1ns / 1ps
interface rhr_out_if import rhr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color_out;

    modport source(output valid, color_out, input ready);
    modport sink(input valid, color_out, output ready);
endinterface

### rtl/rhr_front.sv
// Front end: accepts colors and attaches the three rotation coefficients.
// Depends on rhr_pkg and rhr_in_if.
`timescale 1ns / 1ps
module rhr_front import rhr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    rhr_in_if.sink                   i_in_ch,
    input  logic [COS_W-1:0]         i_cosine,
    input  logic signed [SIN_W-1:0]  i_sine,
    output logic                     o_vld,
    output t_entry                   o_entry,
    input  logic                     i_ready
);
    logic                  r_vld;
    logic                  n_vld;
    t_entry                r_entry;
    t_entry                w_entry;
    logic [20:0]           w_c1_p;
    logic signed [COEF_W-1:0] w_diff;
    logic signed [23:0]    w_base_p;
    logic signed [22:0]    w_sin_p;
    t_coef                 w_base;
    t_coef                 w_sterm;
    logic                  w_take;

    assign i_in_ch.ready = !r_vld || i_ready;
    assign w_take        = i_in_ch.valid && i_in_ch.ready;

    // Constant multiplies; an arithmetic shift gives the floor.
    always_comb begin
        w_c1_p   = 21'(i_cosine) * 21'(K_TWO_THIRDS);
        w_diff   = K_ONE - signed'({2'b00, i_cosine});
        w_base_p = 24'(w_diff) * 24'(K_THIRD_S);
        w_sin_p  = 23'(i_sine) * 23'(K_ROOT_THIRD);
        w_base   = w_base_p[22:10];
        w_sterm  = w_sin_p[22:10];

        w_entry.color  = i_in_ch.color_in;
        w_entry.transp = i_in_ch.transparent_slot;
        w_entry.c1     = K_THIRD + signed'({2'b00, w_c1_p[20:10]});
        w_entry.c2     = w_base - w_sterm;
        w_entry.c3     = w_base + w_sterm;
    end

    always_comb begin
        n_vld = r_vld;
        if (i_in_ch.ready) begin
            n_vld = i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_entry <= w_entry;
        end
    end

    assign o_vld   = r_vld;
    assign o_entry = r_entry;
endmodule

### rtl/rhr_queue.sv
// Short FIFO that decouples the front end from the arithmetic back end.
// Depends on rhr_pkg.
`timescale 1ns / 1ps
module rhr_queue import rhr_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push_vld,
    input  t_entry                     i_push_data,
    output logic                       o_push_rdy,
    output logic                       o_pop_vld,
    output t_entry                     o_pop_data,
    input  logic                       i_pop_rdy,
    output t_q_status                  o_status,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_push_rdy = (r_cnt != FULLC);
    assign o_pop_vld  = (r_cnt != '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign w_push     = i_push_vld && o_push_rdy;
    assign w_pop      = o_pop_vld && i_pop_rdy;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_status.full  = !o_push_rdy;
    assign o_status.empty = !o_pop_vld;
    assign o_count        = r_cnt;
endmodule

### rtl/rhr_back.sv
// Back end: nine channel products, then sum, round, clamp and repack.
// Depends on rhr_pkg and rhr_out_if.
`timescale 1ns / 1ps
module rhr_back import rhr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_entry  i_entry,
    output logic    o_rdy,
    rhr_out_if.source o_out_ch
);
    // Stage one: products
    logic               r_s1_vld;
    logic               n_s1_vld;
    t_prod              r_prod [9];
    t_prod              w_prod [9];
    logic [COLOR_W-1:0] r_s1_color;
    logic               r_s1_transp;
    // Stage two: output register
    logic               r_out_vld;
    logic               n_out_vld;
    logic [COLOR_W-1:0] r_out_color;
    logic [COLOR_W-1:0] w_rot;
    logic signed [CH_W:0] w_r;
    logic signed [CH_W:0] w_g;
    logic signed [CH_W:0] w_b;
    logic               w_out_rdy;
    logic               w_s1_rdy;

    function automatic logic [CH_W-1:0] round_clamp(input t_prod a, input t_prod b,
                                                   input t_prod c);
        logic signed [SUM_W-1:0] v;
        v = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + K_HALF;
        if (v < 0) begin
            return '0;
        end else if (v >= K_TOP) begin
            return CH_MAX;
        end
        return v[FRAC+CH_W-1:FRAC];
    endfunction

    assign w_out_rdy = !r_out_vld || o_out_ch.ready;
    assign w_s1_rdy  = !r_s1_vld || w_out_rdy;
    assign o_rdy     = w_s1_rdy;

    always_comb begin
        w_r = signed'({1'b0, i_entry.color[CH_W-1:0]});
        w_g = signed'({1'b0, i_entry.color[2*CH_W-1:CH_W]});
        w_b = signed'({1'b0, i_entry.color[3*CH_W-1:2*CH_W]});
        // red row, green row, blue row
        w_prod[0] = PROD_W'(w_r) * PROD_W'(i_entry.c1);
        w_prod[1] = PROD_W'(w_g) * PROD_W'(i_entry.c2);
        w_prod[2] = PROD_W'(w_b) * PROD_W'(i_entry.c3);
        w_prod[3] = PROD_W'(w_r) * PROD_W'(i_entry.c3);
        w_prod[4] = PROD_W'(w_g) * PROD_W'(i_entry.c1);
        w_prod[5] = PROD_W'(w_b) * PROD_W'(i_entry.c2);
        w_prod[6] = PROD_W'(w_r) * PROD_W'(i_entry.c2);
        w_prod[7] = PROD_W'(w_g) * PROD_W'(i_entry.c3);
        w_prod[8] = PROD_W'(w_b) * PROD_W'(i_entry.c1);
    end

    always_comb begin
        w_rot = {round_clamp(r_prod[6], r_prod[7], r_prod[8]),
                 round_clamp(r_prod[3], r_prod[4], r_prod[5]),
                 round_clamp(r_prod[0], r_prod[1], r_prod[2])};
    end

    always_comb begin
        n_s1_vld  = r_s1_vld;
        n_out_vld = r_out_vld;
        if (w_s1_rdy) begin
            n_s1_vld = i_vld;
        end
        if (w_out_rdy) begin
            n_out_vld = r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld && w_s1_rdy) begin
            r_prod      <= w_prod;
            r_s1_color  <= i_entry.color;
            r_s1_transp <= i_entry.transp;
        end
        if (r_s1_vld && w_out_rdy) begin
            r_out_color <= r_s1_transp ? r_s1_color : w_rot;
        end
    end

    assign o_out_ch.valid     = r_out_vld;
    assign o_out_ch.color_out = r_out_color;
endmodule

### rtl/rgb555_hue_rotate.sv
// Channel    | dir | handshake     | payload
// i_in_ch    | in  | valid/ready   | color_in[14:0], transparent_slot
// o_out_ch   | out | valid/ready   | color_out[14:0]
// i_cfg_*    | in  | write enable  | idx 0 cosine_q10[10:0], idx 1 sine_q10[11:0]
//
// One color per cycle sustained while o_out_ch.ready stays high; a transaction
// passes the front register, queue, product stage and output register.
// Throughput is set by the single pass through the coefficient multiplies in
// the front and the nine channel products in the back, both one per cycle.
// Synchronous active-low reset empties every stage; cosine resets to 1024, sine to 0.
// At full rate the queue holds one entry, so an output stall lets the front take
// QDEPTH-1 more colors before i_in_ch.ready drops.
`timescale 1ns / 1ps
`include "rgb555_hue_rotate_defines.svh"
module rgb555_hue_rotate import rhr_pkg::*; #(
    parameter int QDEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rhr_in_if.sink               i_in_ch,
    rhr_out_if.source            o_out_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0]    i_cfg_data
);
    logic [COS_W-1:0]          r_cosine;
    logic signed [SIN_W-1:0]   r_sine;
    logic                      w_f_vld;
    t_entry                    w_f_entry;
    logic                      w_q_push_rdy;
    logic                      w_q_vld;
    t_entry                    w_q_entry;
    logic                      w_b_rdy;
    t_q_status                 w_q_st;
    logic [$clog2(QDEPTH+1)-1:0] w_q_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cosine <= COS_RESET;
            r_sine   <= SIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COSINE: r_cosine <= i_cfg_data[COS_W-1:0];
                CFG_SINE:   r_sine   <= signed'(i_cfg_data[SIN_W-1:0]);
                default: ;
            endcase
        end
    end

    rhr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (i_in_ch),
        .i_cosine (r_cosine),
        .i_sine   (r_sine),
        .o_vld    (w_f_vld),
        .o_entry  (w_f_entry),
        .i_ready  (w_q_push_rdy)
    );

    rhr_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (w_f_vld),
        .i_push_data (w_f_entry),
        .o_push_rdy  (w_q_push_rdy),
        .o_pop_vld   (w_q_vld),
        .o_pop_data  (w_q_entry),
        .i_pop_rdy   (w_b_rdy),
        .o_status    (w_q_st),
        .o_count     (w_q_cnt)
    );

    rhr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_q_vld),
        .i_entry  (w_q_entry),
        .o_rdy    (w_b_rdy),
        .o_out_ch (o_out_ch)
    );

    `RHR_ASSERT(a_q_count_range, w_q_cnt <= ($clog2(QDEPTH+1))'(QDEPTH))
    `RHR_ASSERT(a_q_status_match, w_q_st.full == (w_q_cnt == ($clog2(QDEPTH+1))'(QDEPTH)))
    `RHR_ASSERT(a_backpressure, (w_q_st.full && w_f_vld) |-> !i_in_ch.ready)
    `RHR_ASSERT_RST(a_reset_empty, !i_rst_n |=> (!o_out_ch.valid && w_q_st.empty))
endmodule

### tb/sv/rgb555_hue_rotate_tb.sv
// Self-checking testbench for rgb555_hue_rotate: directed color table, then random
// colors under several hue angles, with random gaps and stalls on both channels.
// Depends on rhr_pkg, rhr_in_if, rhr_out_if and the rgb555_hue_rotate RTL.
`timescale 1ns / 1ps
module rgb555_hue_rotate_tb;
    import rhr_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int SETTLE       = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 10;
    localparam int PHASE_COLORS = 65;
    localparam int Q_THIRD      = 341;
    localparam int Q_TWO_THIRDS = 682;
    localparam int Q_ROOT_THIRD = 591;
    localparam int Q_ONE        = 1024;
    localparam int Q_HALF       = 512;
    localparam int CH_TOP       = 31;

    typedef struct {
        logic [COS_W-1:0]        cos_v;
        logic signed [SIN_W-1:0] sin_v;
        logic [COLOR_W-1:0]      color;
        logic                    transp;
        logic                    known;
        logic [COLOR_W-1:0]      result;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_COSINE;
    logic [CFG_DW-1:0]  i_cfg_data = '0;

    rhr_in_if  in_ch();
    rhr_out_if out_ch();

    rgb555_hue_rotate DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the angle registers
    logic [COS_W-1:0]        cos_reg = COS_RESET;
    logic signed [SIN_W-1:0] sin_reg = SIN_RESET;

    logic [COLOR_W-1:0] expected_colors [$];
    int  err_count     = 0;
    int  colors_seen   = 0;
    int  transp_sent   = 0;
    int  angles_used   = 1;
    int  cycle_count   = 0;
    bit  steady        = 1'b0;

    // Reset angle is identity, so those rows and transparent rows are typed in.
    t_dir_row directed_rows [22] = '{
        '{11'd1024,     0, 15'h0000, 1'b0, 1'b1, 15'h0000},
        '{11'd1024,     0, 15'h7FFF, 1'b0, 1'b1, 15'h7FFF},
        '{11'd1024,     0, 15'h001F, 1'b0, 1'b1, 15'h001F},
        '{11'd1024,     0, 15'h03E0, 1'b0, 1'b1, 15'h03E0},
        '{11'd1024,     0, 15'h7C00, 1'b0, 1'b1, 15'h7C00},
        '{11'd1024,     0, 15'h5555, 1'b0, 1'b1, 15'h5555},
        '{11'd1024,     0, 15'h2AAA, 1'b0, 1'b1, 15'h2AAA},
        '{11'd1024,     0, 15'h7FFF, 1'b1, 1'b1, 15'h7FFF},
        '{11'd1024,     0, 15'h1234, 1'b1, 1'b1, 15'h1234},
        '{11'd0,        0, 15'h7FFF, 1'b0, 1'b0, 15'h0000},
        '{11'd0,        0, 15'h001F, 1'b0, 1'b0, 15'h0000},
        '{11'd0,     1024, 15'h001F, 1'b0, 1'b0, 15'h0000},
        '{11'd0,     1024, 15'h03E0, 1'b0, 1'b0, 15'h0000},
        '{11'd0,     1024, 15'h7C00, 1'b0, 1'b0, 15'h0000},
        '{11'd0,    -1024, 15'h001F, 1'b0, 1'b0, 15'h0000},
        '{11'd0,    -1024, 15'h7FFF, 1'b0, 1'b0, 15'h0000},
        '{11'd2047,  2047, 15'h001F, 1'b0, 1'b0, 15'h0000},
        '{11'd2047,  2047, 15'h7FFF, 1'b0, 1'b0, 15'h0000},
        '{11'd2047, -2048, 15'h03E0, 1'b0, 1'b0, 15'h0000},
        '{11'd2047, -2048, 15'h4321, 1'b1, 1'b1, 15'h4321},
        '{11'd0,    -2048, 15'h7C00, 1'b0, 1'b0, 15'h0000},
        '{11'd0,     2047, 15'h0421, 1'b0, 1'b0, 15'h0000}
    };

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rgb555_hue_rotate_tb: errors");
            $finish;
        end
    end

    function automatic logic [CH_W-1:0] round_sat(input int v);
        v = v + Q_HALF;
        if (v < 0)
            return '0;
        if (v >= 32 * Q_ONE)
            return CH_W'(CH_TOP);
        return CH_W'(v >>> FRAC);
    endfunction

    // Rotated color for the current angle; >>> on signed ints floors as required.
    function automatic logic [COLOR_W-1:0] rotate_hue(input logic [COLOR_W-1:0] c,
                                                      input logic transp);
        int r, g, b, c1, c2, c3, base, skew;
        if (transp)
            return c;
        r    = int'(c[4:0]);
        g    = int'(c[9:5]);
        b    = int'(c[14:10]);
        c1   = Q_THIRD + ((int'(cos_reg) * Q_TWO_THIRDS) >>> FRAC);
        base = ((Q_ONE - int'(cos_reg)) * Q_THIRD) >>> FRAC;
        skew = (Q_ROOT_THIRD * int'(sin_reg)) >>> FRAC;
        c2   = base - skew;
        c3   = base + skew;
        return {round_sat(r * c2 + g * c3 + b * c1),
                round_sat(r * c3 + g * c1 + b * c2),
                round_sat(r * c1 + g * c2 + b * c3)};
    endfunction

    // Sender: random gap, then hold valid until the transaction completes.
    task automatic send_color(input logic [COLOR_W-1:0] c, input logic transp,
                              input logic known, input logic [COLOR_W-1:0] typed);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.color_in         <= c;
        in_ch.transparent_slot <= transp;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_colors.push_back(known ? typed : rotate_hue(c, transp));
        if (transp)
            transp_sent++;
    endtask

    // Drains the pipe first, then writes both registers back to back.
    task automatic set_angle(input logic [COS_W-1:0] cos_v,
                             input logic signed [SIN_W-1:0] sin_v);
        in_ch.valid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_COSINE;
        i_cfg_data <= CFG_DW'(cos_v);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SINE;
        i_cfg_data <= CFG_DW'(sin_v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cos_reg     = cos_v;
        sin_reg     = sin_v;
        angles_used++;
    endtask

    task automatic pick_angle(input int phase);
        logic [COS_W-1:0]        cos_v;
        logic signed [SIN_W-1:0] sin_v;
        int kind;
        int cos_pick [3] = '{0, 1024, 2047};
        int sin_pick [5] = '{-2048, -1024, 0, 1024, 2047};
        kind = (phase == 0) ? 0 : $urandom_range(0, 2);
        case (kind)
            0: begin
                cos_v = COS_W'(cos_pick[$urandom_range(0, 2)]);
                sin_v = SIN_W'(sin_pick[$urandom_range(0, 4)]);
            end
            1: begin
                cos_v = COS_W'($urandom_range(0, 1024));
                sin_v = SIN_W'(int'($urandom_range(0, 2048)) - 1024);
            end
            default: begin
                cos_v = COS_W'($urandom);
                sin_v = SIN_W'($urandom);
            end
        endcase
        set_angle(cos_v, sin_v);
    endtask

    // Receiver: random stall per result, compare against the oldest expectation.
    initial begin
        int stall;
        logic [COLOR_W-1:0] want;
        out_ch.ready <= 1'b0;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            colors_seen++;
            if (expected_colors.size() == 0) begin
                $error("unexpected result: color_out %h with nothing pending",
                       out_ch.color_out);
                err_count++;
            end else begin
                want = expected_colors.pop_front();
                if (out_ch.color_out !== want) begin
                    $error("color_out mismatch: expected %h, got %h",
                           want, out_ch.color_out);
                    err_count++;
                end
            end
        end
    end

    initial begin
        logic [COLOR_W-1:0] c;
        in_ch.valid            <= 1'b0;
        in_ch.color_in         <= '0;
        in_ch.transparent_slot <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].cos_v != cos_reg || directed_rows[i].sin_v != sin_reg)
                set_angle(directed_rows[i].cos_v, directed_rows[i].sin_v);
            send_color(directed_rows[i].color, directed_rows[i].transp,
                       directed_rows[i].known, directed_rows[i].result);
        end

        for (int p = 0; p < PHASES; p++) begin
            steady = 1'b0;
            pick_angle(p);
            steady = (p % 4 == 1);
            for (int k = 0; k < PHASE_COLORS; k++) begin
                if ($urandom_range(0, 7) == 0)
                    // saturated channels only
                    c = {{5{$urandom_range(0, 1) == 1}}, {5{$urandom_range(0, 1) == 1}},
                         {5{$urandom_range(0, 1) == 1}}};
                else
                    c = COLOR_W'($urandom);
                send_color(c, $urandom_range(0, 7) == 0, 1'b0, '0);
            end
        end

        steady = 1'b0;
        in_ch.valid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (4 * SETTLE) @(posedge i_clk);

        $display("%0d colors checked over %0d angle settings, %0d transparent",
                 colors_seen, angles_used, transp_sent);
        $display("%0d mismatches or stray results", err_count);
        if (err_count == 0)
            $display("rgb555_hue_rotate_tb: clean");
        else
            $display("rgb555_hue_rotate_tb: errors");
        $finish;
    end
endmodule
